### rtl/pps_pkg.sv
package pps_pkg;

  localparam int MAX_PROCS_DEF = 16;
  localparam int TIME_BITS_DEF = 20;

  localparam int ARR_W  = 16;
  localparam int BUR_W  = 16;
  localparam int PRI_W  = 8;
  localparam int PIDX_W = 4;
  localparam int TURN_W = 20;

  localparam logic OP_LOAD = 1'b0;
  localparam logic OP_TICK = 1'b1;

  typedef struct packed {
    logic             opcode;
    logic [ARR_W-1:0] arrival;
    logic [BUR_W-1:0] burst;
    logic [PRI_W-1:0] prio_level;
  } cmd_t;

  typedef struct packed {
    logic              accepted;
    logic              busy_res;
    logic [PIDX_W-1:0] proc_index;
    logic              finished;
    logic [TURN_W-1:0] turnaround;
    logic [TURN_W-1:0] waiting;
    logic              all_done;
  } rsp_t;

  typedef struct packed {
    logic [PRI_W-1:0] prio;
    logic [ARR_W-1:0] arrival;
    logic [BUR_W-1:0] burst;
    logic [BUR_W-1:0] remaining;
  } entry_t;

endpackage

### rtl/pps_chan.sv
interface pps_chan #(
  parameter type T = logic
);
  logic valid;
  logic ready;
  T     payload;

  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);
endinterface

### rtl/pps_cell.sv
module pps_cell
  import pps_pkg::*;
#(
  parameter int TIME_BITS = TIME_BITS_DEF,
  parameter int IDX_W     = 4,
  parameter int IDX       = 0
) (
  input  logic                 clk,
  input  logic                 live,
  input  logic                 wr_en,
  input  cmd_t                 wr_data,
  input  logic                 dec_en,
  input  logic [TIME_BITS-1:0] now_time,
  input  logic                 prev_found,
  input  logic [IDX_W-1:0]     prev_idx,
  input  entry_t               prev_entry,
  output logic                 best_found,
  output logic [IDX_W-1:0]     best_idx,
  output entry_t               best_entry
);

  localparam int CW = (TIME_BITS > ARR_W) ? TIME_BITS : ARR_W;

  entry_t entry;
  logic   eligible;
  logic   take;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      entry.prio      <= wr_data.prio_level;
      entry.arrival   <= wr_data.arrival;
      entry.burst     <= wr_data.burst;
      entry.remaining <= wr_data.burst;
    end else if (dec_en) begin
      entry.remaining <= entry.remaining - BUR_W'(1);
    end
  end

  assign eligible = live && (CW'(entry.arrival) <= CW'(now_time))
                    && (entry.remaining != '0);

  assign take = eligible && (!prev_found || (entry.prio < prev_entry.prio)
                || ((entry.prio == prev_entry.prio)
                    && (entry.arrival < prev_entry.arrival)));

  always_ff @(posedge clk) begin
    if (take) begin
      best_found <= 1'b1;
      best_idx   <= IDX_W'(IDX);
      best_entry <= entry;
    end else begin
      best_found <= prev_found;
      best_idx   <= prev_idx;
      best_entry <= prev_entry;
    end
  end

endmodule

### rtl/preemptive_priority_scheduler.sv
// Preemptive priority scheduler. A load transaction (opcode 0) stores one process
// entry (arrival, burst, priority) in the next free slot of a table of MAX_PROCS
// entries; a full table drops the load with accepted = 0. A tick transaction
// (opcode 1) runs the best eligible process for one time unit: the pick passes
// slot by slot along a row of MAX_PROCS cells, one cell per cycle. One
// transaction is worked on at a time; the result sits in an output register, and
// the next transaction is taken as soon as that register has room. Lower priority
// values win, ties go to earlier arrival, then to the lower slot. The time counter
// saturates at 2**TIME_BITS - 1.
module preemptive_priority_scheduler
  import pps_pkg::*;
#(
  parameter int MAX_PROCS = MAX_PROCS_DEF,
  parameter int TIME_BITS = TIME_BITS_DEF
) (
  input logic    clk,
  input logic    rst,
  pps_chan.sink   cmd,
  pps_chan.source res
);

  localparam int IDX_W = (MAX_PROCS > 1) ? $clog2(MAX_PROCS) : 1;
  localparam int CNT_W = $clog2(MAX_PROCS + 1);
  localparam int CW    = (TIME_BITS > ARR_W) ? TIME_BITS : ARR_W;

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_SCAN = 2'd1;
  localparam logic [1:0] ST_EMIT = 2'd2;

  localparam logic [IDX_W-1:0] LAST = IDX_W'(MAX_PROCS - 1);

  logic [1:0]           state;
  logic [IDX_W-1:0]     cnt;
  rsp_t                 pend;
  logic [CNT_W-1:0]     loaded_count;
  logic [CNT_W-1:0]     done_count;
  logic [TIME_BITS-1:0] now_time;

  logic                 found_c [0:MAX_PROCS];
  logic [IDX_W-1:0]     idx_c   [0:MAX_PROCS];
  entry_t               entry_c [0:MAX_PROCS];

  logic                 accept;
  logic                 load_go;
  logic                 tick_done;
  logic                 room;
  logic                 fin;
  logic [TIME_BITS-1:0] now_next;
  logic [CW-1:0]        tat;
  logic [CW-1:0]        wt;
  logic [CNT_W-1:0]     done_next;
  rsp_t                 load_rsp;

  assign cmd.ready = (state == ST_IDLE);
  assign accept    = cmd.valid && cmd.ready;
  assign room      = (loaded_count < CNT_W'(MAX_PROCS));
  assign load_go   = accept && (cmd.payload.opcode == OP_LOAD) && room;
  assign tick_done = (state == ST_SCAN) && (cnt == LAST);

  assign found_c[0] = 1'b0;
  assign idx_c[0]   = '0;
  assign entry_c[0] = '0;

  for (genvar i = 0; i < MAX_PROCS; i++) begin : g_cell
    pps_cell #(
      .TIME_BITS (TIME_BITS),
      .IDX_W     (IDX_W),
      .IDX       (i)
    ) u_cell (
      .clk        (clk),
      .live       (CNT_W'(i) < loaded_count),
      .wr_en      (load_go && (loaded_count == CNT_W'(i))),
      .wr_data    (cmd.payload),
      .dec_en     (tick_done && found_c[MAX_PROCS] && (idx_c[MAX_PROCS] == IDX_W'(i))),
      .now_time   (now_time),
      .prev_found (found_c[i]),
      .prev_idx   (idx_c[i]),
      .prev_entry (entry_c[i]),
      .best_found (found_c[i+1]),
      .best_idx   (idx_c[i+1]),
      .best_entry (entry_c[i+1])
    );
  end

  assign now_next = (now_time == '1) ? now_time : now_time + TIME_BITS'(1);
  assign fin      = found_c[MAX_PROCS] && (entry_c[MAX_PROCS].remaining == BUR_W'(1));
  assign tat      = CW'(now_next) - CW'(entry_c[MAX_PROCS].arrival);
  assign wt       = (tat >= CW'(entry_c[MAX_PROCS].burst))
                    ? tat - CW'(entry_c[MAX_PROCS].burst) : '0;
  assign done_next = fin ? done_count + CNT_W'(1) : done_count;

  always_comb begin
    load_rsp = '0;
    if (room) begin
      load_rsp.accepted   = 1'b1;
      load_rsp.proc_index = PIDX_W'(loaded_count);
      if (cmd.payload.burst == '0) begin
        load_rsp.all_done = (done_count + CNT_W'(1)) == (loaded_count + CNT_W'(1));
      end else begin
        load_rsp.all_done = done_count == (loaded_count + CNT_W'(1));
      end
    end else begin
      load_rsp.all_done = done_count == loaded_count;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= ST_IDLE;
      cnt          <= '0;
      loaded_count <= '0;
      done_count   <= '0;
      now_time     <= '0;
      res.valid    <= 1'b0;
    end else begin
      if ((state == ST_EMIT) && (!res.valid || res.ready)) begin
        res.valid <= 1'b1;
      end else if (res.valid && res.ready) begin
        res.valid <= 1'b0;
      end
      case (state)
        ST_IDLE: begin
          if (accept) begin
            cnt <= '0;
            if (cmd.payload.opcode == OP_TICK) begin
              state <= ST_SCAN;
              pend  <= '0;
            end else begin
              state <= ST_EMIT;
              pend  <= load_rsp;
              if (room) begin
                loaded_count <= loaded_count + CNT_W'(1);
                if (cmd.payload.burst == '0) begin
                  done_count <= done_count + CNT_W'(1);
                end
              end
            end
          end
        end
        ST_SCAN: begin
          cnt <= cnt + IDX_W'(1);
          if (tick_done) begin
            state           <= ST_EMIT;
            now_time        <= now_next;
            done_count      <= done_next;
            pend.accepted   <= 1'b1;
            pend.busy_res   <= found_c[MAX_PROCS];
            pend.proc_index <= found_c[MAX_PROCS] ? PIDX_W'(idx_c[MAX_PROCS]) : '0;
            pend.finished   <= fin;
            pend.turnaround <= fin ? TURN_W'(tat) : '0;
            pend.waiting    <= fin ? TURN_W'(wt) : '0;
            pend.all_done   <= done_next == loaded_count;
          end
        end
        ST_EMIT: begin
          if (!res.valid || res.ready) begin
            state <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if ((state == ST_EMIT) && (!res.valid || res.ready)) begin
      res.payload <= pend;
    end
  end

  a_done_le_loaded: assert property (@(posedge clk) disable iff (rst)
    done_count <= loaded_count)
    else $error("done count exceeds loaded count");

  a_loaded_cap: assert property (@(posedge clk) disable iff (rst)
    loaded_count <= CNT_W'(MAX_PROCS))
    else $error("loaded count beyond table capacity");

  a_pick_live: assert property (@(posedge clk) disable iff (rst)
    (tick_done && found_c[MAX_PROCS]) |-> (CNT_W'(idx_c[MAX_PROCS]) < loaded_count))
    else $error("picked an unloaded slot");

  a_time_mono: assert property (@(posedge clk) disable iff (rst)
    (state == ST_EMIT) |=> (now_time == $past(now_time)))
    else $error("time advanced outside a tick");

endmodule

### tb/tb.sv
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  import pps_pkg::*;

  localparam int MAX_PROCS     = MAX_PROCS_DEF;
  localparam int TIME_BITS     = TIME_BITS_DEF;
  localparam int unsigned TIME_MAX = (1 << TIME_BITS) - 1;
  localparam int NUM_DIRECTED  = 21;
  localparam int NUM_PHASES    = 4;
  localparam int PHASE_ITEMS   = 395;
  localparam int LATE_STEP     = 1000;
  localparam int HOLD_CYCLES   = 400;
  localparam int STALL_LIMIT   = 5000;
  localparam int DRAIN_CYCLES  = MAX_PROCS + 24;
  localparam int IDLE_PLAN [NUM_PHASES]  = '{0, 75, 0, 12};
  localparam int STALL_PLAN [NUM_PHASES] = '{0, 0, 75, 12};

  typedef struct {
    logic        op;
    int unsigned arr;
    int unsigned bur;
    int unsigned pri;
    bit          typed;
    rsp_t        rsp;
  } dir_row_t;

  logic clk;
  logic rst;

  pps_chan #(.T(cmd_t)) cmd_if ();
  pps_chan #(.T(rsp_t)) res_if ();

  preemptive_priority_scheduler #(
    .MAX_PROCS(MAX_PROCS),
    .TIME_BITS(TIME_BITS)
  ) dut (
    .clk(clk),
    .rst(rst),
    .cmd(cmd_if),
    .res(res_if)
  );

  logic [ARR_W-1:0] arr_tbl [MAX_PROCS];
  logic [BUR_W-1:0] bur_tbl [MAX_PROCS];
  logic [BUR_W-1:0] rem_tbl [MAX_PROCS];
  logic [PRI_W-1:0] pri_tbl [MAX_PROCS];
  int unsigned n_loaded  = 0;
  int unsigned n_done    = 0;
  int unsigned clock_now = 0;

  rsp_t outcome_q [$];
  int   mismatches    = 0;
  int   send_idle_pct = 0;
  int   stall_pct     = 0;
  bit   hold_request  = 1'b0;

  // op, arrival, burst, priority, typed, result
  dir_row_t directed_rows [NUM_DIRECTED] = '{
    '{OP_TICK, 0, 0, 0, 1'b1, '{1'b1, 1'b0, 4'd0, 1'b0, 20'd0, 20'd0, 1'b1}},
    '{OP_LOAD, 0, 1, 0, 1'b1, '{1'b1, 1'b0, 4'd0, 1'b0, 20'd0, 20'd0, 1'b0}},
    '{OP_LOAD, 0, 0, 0, 1'b1, '{1'b1, 1'b0, 4'd1, 1'b0, 20'd0, 20'd0, 1'b0}},
    '{OP_TICK, 0, 0, 0, 1'b1, '{1'b1, 1'b1, 4'd0, 1'b1, 20'd2, 20'd1, 1'b1}},
    '{OP_TICK, 0, 0, 0, 1'b1, '{1'b1, 1'b0, 4'd0, 1'b0, 20'd0, 20'd0, 1'b1}},
    '{OP_LOAD, 2, 3, 5, 1'b0, '0},
    '{OP_LOAD, 2, 2, 5, 1'b0, '0},
    '{OP_LOAD, 1, 2, 5, 1'b0, '0},
    '{OP_LOAD, 0, 1, 255, 1'b0, '0},
    '{OP_TICK, 0, 0, 0, 1'b0, '0},
    '{OP_LOAD, 0, 1, 0, 1'b0, '0},
    '{OP_TICK, 0, 0, 0, 1'b0, '0},
    '{OP_LOAD, 12, 2, 0, 1'b0, '0},
    '{OP_TICK, 0, 0, 0, 1'b0, '0},
    '{OP_TICK, 0, 0, 0, 1'b0, '0},
    '{OP_TICK, 0, 0, 0, 1'b0, '0},
    '{OP_TICK, 0, 0, 0, 1'b0, '0},
    '{OP_TICK, 0, 0, 0, 1'b0, '0},
    '{OP_TICK, 0, 0, 0, 1'b0, '0},
    '{OP_TICK, 0, 0, 0, 1'b0, '0},
    '{OP_TICK, 0, 0, 0, 1'b0, '0}
  };

  function automatic rsp_t schedule_step(cmd_t c);
    rsp_t        r;
    bit          found;
    int unsigned pick;
    int unsigned span;
    r = '0;
    found = 1'b0;
    pick = 0;
    if (c.opcode == OP_LOAD) begin
      if (n_loaded < MAX_PROCS) begin
        arr_tbl[n_loaded] = c.arrival;
        bur_tbl[n_loaded] = c.burst;
        rem_tbl[n_loaded] = c.burst;
        pri_tbl[n_loaded] = c.prio_level;
        if (c.burst == '0) n_done++;
        r.accepted = 1'b1;
        r.proc_index = PIDX_W'(n_loaded);
        n_loaded++;
      end
    end else begin
      for (int i = 0; i < int'(n_loaded); i++) begin
        if (arr_tbl[i] <= clock_now && rem_tbl[i] != '0 &&
            (!found || pri_tbl[i] < pri_tbl[pick] ||
             (pri_tbl[i] == pri_tbl[pick] && arr_tbl[i] < arr_tbl[pick]))) begin
          pick = i;
          found = 1'b1;
        end
      end
      r.accepted = 1'b1;
      if (clock_now < TIME_MAX) clock_now++;
      if (found) begin
        r.busy_res = 1'b1;
        r.proc_index = PIDX_W'(pick);
        rem_tbl[pick]--;
        if (rem_tbl[pick] == '0) begin
          span = clock_now - arr_tbl[pick];
          r.finished = 1'b1;
          r.turnaround = TURN_W'(span);
          r.waiting = (span >= bur_tbl[pick]) ? TURN_W'(span - bur_tbl[pick]) : '0;
          n_done++;
        end
      end
    end
    r.all_done = (n_done == n_loaded);
    return r;
  endfunction

  function automatic cmd_t draw_job(int step);
    cmd_t c;
    bit   want_load;
    int   lo;
    c.opcode = OP_TICK;
    c.arrival = ARR_W'($urandom);
    c.burst = BUR_W'($urandom);
    c.prio_level = PRI_W'($urandom);
    if (n_loaded == MAX_PROCS) want_load = ($urandom_range(9) == 0);
    else if (step >= LATE_STEP) want_load = ($urandom_range(19) == 0);
    else if (n_loaded < MAX_PROCS - 2) want_load = ($urandom_range(69) == 0);
    else want_load = 1'b0;
    if (want_load) begin
      c.opcode = OP_LOAD;
      if (n_loaded < MAX_PROCS) begin
        lo = int'(clock_now) - 20;
        if (lo < 0) lo = 0;
        c.arrival = ARR_W'($urandom_range(lo + 100, lo));
        c.burst = ($urandom_range(15) == 0) ? '0 : BUR_W'($urandom_range(150, 1));
        c.prio_level = ($urandom_range(7) == 0) ? PRI_W'($urandom) :
                                                  PRI_W'($urandom_range(3));
        if (n_loaded == MAX_PROCS - 2) begin
          c.burst = '1;
          c.prio_level = '1;
        end
        if (n_loaded == MAX_PROCS - 1) c.arrival = '1;
      end
    end
    return c;
  endfunction

  function automatic void check_field(string fname, int unsigned want, int unsigned got);
    if (want != got) begin
      $error("%s mismatch: expected %0d, got %0d", fname, want, got);
      mismatches++;
    end
  endfunction

  function automatic void compare_result(rsp_t got);
    rsp_t want;
    if (outcome_q.size() == 0) begin
      $error("result with no pending transaction: %p", got);
      mismatches++;
    end else begin
      want = outcome_q.pop_front();
      check_field("accepted", want.accepted, got.accepted);
      check_field("busy_res", want.busy_res, got.busy_res);
      check_field("proc_index", want.proc_index, got.proc_index);
      check_field("finished", want.finished, got.finished);
      check_field("turnaround", want.turnaround, got.turnaround);
      check_field("waiting", want.waiting, got.waiting);
      check_field("all_done", want.all_done, got.all_done);
    end
  endfunction

  task automatic offer(cmd_t c, bit typed, rsp_t typed_rsp);
    rsp_t predicted;
    while ($urandom_range(99) < send_idle_pct) begin
      cmd_if.valid <= 1'b0;
      @(posedge clk);
    end
    cmd_if.valid <= 1'b1;
    cmd_if.payload <= c;
    @(posedge clk);
    while (!cmd_if.ready) @(posedge clk);
    predicted = schedule_step(c);
    outcome_q.push_back(typed ? typed_rsp : predicted);
  endtask

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  initial begin
    int hold_left;
    hold_left = 0;
    res_if.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (!rst && res_if.valid && res_if.ready) compare_result(res_if.payload);
      if (hold_request) begin
        hold_request = 1'b0;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        res_if.ready <= 1'b0;
      end else begin
        res_if.ready <= ($urandom_range(99) >= stall_pct);
      end
    end
  end

  initial begin
    int quiet;
    quiet = 0;
    forever begin
      @(posedge clk);
      if ((cmd_if.valid && cmd_if.ready) || (res_if.valid && res_if.ready)) quiet = 0;
      else quiet++;
      if (quiet >= STALL_LIMIT) begin
        $display("DONE: errors detected");
        $finish;
      end
    end
  end

  initial begin
    cmd_t job;
    int   step;
    rst <= 1'b1;
    cmd_if.valid <= 1'b0;
    cmd_if.payload <= '0;
    step = 0;
    repeat (10) @(posedge clk);
    rst <= 1'b0;

    foreach (directed_rows[i]) begin
      job.opcode = directed_rows[i].op;
      job.arrival = ARR_W'(directed_rows[i].arr);
      job.burst = BUR_W'(directed_rows[i].bur);
      job.prio_level = PRI_W'(directed_rows[i].pri);
      offer(job, directed_rows[i].typed, directed_rows[i].rsp);
    end

    for (int p = 0; p < NUM_PHASES; p++) begin
      send_idle_pct = IDLE_PLAN[p];
      stall_pct = STALL_PLAN[p];
      // back up the output while items keep coming
      if (p == 0) hold_request = 1'b1;
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        job = draw_job(step);
        offer(job, 1'b0, '0);
        step++;
      end
    end
    cmd_if.valid <= 1'b0;

    while (outcome_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatches == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule

### filelist.f
rtl/pps_pkg.sv
rtl/pps_chan.sv
rtl/pps_cell.sv
rtl/preemptive_priority_scheduler.sv
tb/tb.sv
